// ===== sv/hps_pkg.sv =====
// ============================================================================
// hps_pkg
// Types and constants shared by the root-port hot-plug sequencer modules.
// ============================================================================
package hps_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int PORT_W   = 5;
  localparam int STAT_W   = 32;
  localparam int SLOT_W   = 8;
  localparam int ACTION_W = 3;
  localparam int SPEED_W  = 4;
  localparam int ACTCNT_W = 5;
  localparam int GEN_W    = 64;
  localparam int CFG_W    = 16;
  localparam int RETRY_W  = 3;
  localparam int PHASE_W  = 3;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMER  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONFD  = 2'd2;

  // Result actions
  localparam logic [ACTION_W-1:0] ACT_NONE     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TIMER    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RERUN    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DISABLE  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CONFIG   = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_INVAL    = 3'd6;

  // Stored per-port phase codes (zero is idle, the reset value)
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STABLE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RESET  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CONFIG = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ERROR  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_POLL     = 2'd1;
  localparam logic [1:0] CFG_RETRY    = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd150;
  localparam logic [CFG_W-1:0]   POLL_RST     = 16'd50;
  localparam logic [RETRY_W-1:0] RETRY_RST    = 3'd5;
  localparam logic [RETRY_W-1:0] RETRY_MAX    = 3'd7;

  // Port status bits
  localparam int ST_CONNECT = 0;
  localparam int ST_ENABLE  = 1;
  localparam int ST_POWER   = 9;
  localparam int ST_SPD_LO  = 10;
  localparam int WR_RESET   = 4;

  // Output queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  // One entry of the per-port state memory
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [RETRY_W-1:0] retry;
    logic [SLOT_W-1:0]  slot;
    logic               enum_flag;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [GEN_W-1:0]    generation;
    logic [ACTCNT_W-1:0] active;
    logic [SPEED_W-1:0]  speed;
    logic [SLOT_W-1:0]   slot;
    logic [STAT_W-1:0]   value;
    logic [PORT_W-1:0]   port;
    logic [ACTION_W-1:0] action;
    logic                last;
  } res_t;

  // Push strobes from the execute stage into the output queue
  typedef struct packed {
    logic p0;
    logic p1;
  } push_t;

endpackage

// ===== sv/hps_ram.sv =====
// ============================================================================
// hps_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module hps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/hps_outq.sv =====
// ============================================================================
// hps_outq
// Result queue: takes up to two result items per cycle, hands out one.
// ============================================================================
module hps_outq
  import hps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  res_t  res0_i,
  input  res_t  res1_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  res_t             q_q [OQ_DEPTH];
  logic [OQ_AW-1:0] head_q, head_d;
  logic [OQ_AW-1:0] tail_q, tail_d;
  logic [OQ_CW-1:0] cnt_q, cnt_d;
  logic [OQ_AW-1:0] tail_p1;
  logic             pop;
  logic [OQ_CW-1:0] n_push;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = q_q[head_q];
  // room for a full two-item burst
  assign room_o      = (cnt_q <= OQ_CW'(OQ_DEPTH - 2));
  assign tail_p1     = tail_q + OQ_AW'(1);
  assign n_push      = OQ_CW'(push_i.p0) + OQ_CW'(push_i.p1);

  // Pointer and fill count update
  always_comb begin
    head_d = pop ? head_q + OQ_AW'(1) : head_q;
    tail_d = tail_q + OQ_AW'(n_push);
    cnt_d  = cnt_q + n_push - OQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i.p0) begin
      q_q[tail_q] <= res0_i;
    end
    if (push_i.p1) begin
      q_q[tail_p1] <= res1_i;
    end
  end

endmodule

// ===== sv/hps_exec.sv =====
// ============================================================================
// hps_exec
// Per-port state machine: reads the port entry, works out the actions and
// writes the entry back. Holds configuration and the global counters.
// ============================================================================
module hps_exec
  import hps_pkg::*;
#(
  parameter int NUM_PORTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   in_kind_i,
  input  logic [PORT_W-1:0]   in_port_i,
  input  logic [STAT_W-1:0]   in_status_i,
  input  logic [SLOT_W-1:0]   in_sid_i,
  input  logic                room_i,
  output push_t               push_o,
  output res_t                res0_o,
  output res_t                res1_o
);

  localparam int IDX_W = $clog2(NUM_PORTS > 1 ? NUM_PORTS : 2);
  localparam int CNT_W = $clog2(NUM_PORTS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CFG_W-1:0]   debounce_q;
  logic [CFG_W-1:0]   poll_q;
  logic [RETRY_W-1:0] limit_q;

  // Global counters
  logic [CNT_W-1:0]   active_q, active_d;
  logic [GEN_W-1:0]   gen_q, gen_d;

  // Latched item
  logic [KIND_W-1:0]  kind_q;
  logic [PORT_W-1:0]  port_q;
  logic [STAT_W-1:0]  stat_q;
  logic [SLOT_W-1:0]  sid_q;
  logic [IDX_W-1:0]   idx_q;

  logic [NUM_PORTS-1:0] valid_q;

  logic               accept;
  logic [IDX_W-1:0]   in_idx;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t             cur, nxt;
  logic               port_ok;
  logic               do_begin, do_end, bump;
  logic [1:0]         g_inc;
  logic [1:0]         n_res;
  logic [ACTION_W-1:0] a0_act, a1_act;
  logic [STAT_W-1:0]  a0_val, a1_val;
  logic [SLOT_W-1:0]  a0_slot;
  logic [SPEED_W-1:0] a1_speed;
  logic               wr_en;

  assign in_ready_o = (state_q == S_IDLE) && room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_idx     = IDX_W'(in_port_i - PORT_W'(1));

  // Per-port state memory
  hps_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_PORTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q),
    .wdata_i (nxt),
    .raddr_i (in_idx),
    .rdata_o (rdata)
  );

  // Entries never written read as the reset value
  assign cur = valid_q[idx_q] ? entry_t'(rdata) : '0;

  assign port_ok = (port_q != '0) && (32'(port_q) <= 32'(NUM_PORTS))
                   && (kind_q <= KIND_CONFD);

  // Step logic
  always_comb begin
    nxt      = cur;
    do_begin = 1'b0;
    do_end   = 1'b0;
    bump     = 1'b0;
    n_res    = 2'd0;
    a0_act   = ACT_NONE;
    a0_val   = '0;
    a0_slot  = '0;
    a1_act   = ACT_NONE;
    a1_val   = '0;
    a1_speed = '0;
    if (port_ok) begin
      case (kind_q)
        KIND_STATUS: begin
          if (stat_q[ST_CONNECT]) begin
            if (cur.phase == PH_IDLE) begin
              nxt.phase = PH_STABLE;
              nxt.retry = '0;
              do_begin  = 1'b1;
              n_res     = 2'd1;
              a0_act    = ACT_TIMER;
              a0_val    = STAT_W'(debounce_q);
            end
          end else begin
            nxt.phase = PH_IDLE;
            do_end    = 1'b1;
            if (cur.slot != '0) begin
              n_res   = 2'd1;
              a0_act  = ACT_INVAL;
              a0_slot = cur.slot;
            end
          end
        end
        KIND_TIMER: begin
          if (!stat_q[ST_CONNECT] && cur.phase != PH_IDLE) begin
            // disconnect seen on a poll
            nxt.phase = PH_IDLE;
            do_end    = 1'b1;
          end else begin
            case (cur.phase)
              PH_IDLE: begin
              end
              PH_STABLE: begin
                bump      = 1'b1;
                nxt.phase = PH_RESET;
                n_res     = 2'd2;
                a0_act    = ACT_WRITE;
                a0_val    = (STAT_W'(stat_q[ST_POWER]) << ST_POWER)
                            | (STAT_W'(1) << WR_RESET);
                a1_act    = ACT_TIMER;
                a1_val    = STAT_W'(poll_q);
              end
              PH_RESET: begin
                bump = 1'b1;
                if (stat_q[ST_ENABLE]) begin
                  nxt.phase = PH_CONFIG;
                  n_res     = 2'd1;
                  a0_act    = ACT_RERUN;
                end else begin
                  if (cur.retry != RETRY_MAX) begin
                    nxt.retry = cur.retry + RETRY_W'(1);
                  end
                  if (cur.retry < limit_q) begin
                    n_res  = 2'd1;
                    a0_act = ACT_TIMER;
                    a0_val = STAT_W'(poll_q);
                  end else begin
                    nxt.phase = PH_ERROR;
                    do_end    = 1'b1;
                  end
                end
              end
              PH_CONFIG: begin
                bump      = 1'b1;
                nxt.phase = PH_IDLE;
                do_end    = 1'b1;
                a1_act    = ACT_CONFIG;
                a1_speed  = stat_q[ST_SPD_LO +: SPEED_W];
                if (cur.slot != '0) begin
                  // disable the old slot first
                  nxt.slot = '0;
                  n_res    = 2'd2;
                  a0_act   = ACT_DISABLE;
                  a0_slot  = cur.slot;
                end else begin
                  n_res = 2'd1;
                end
              end
              default: begin
                nxt.phase = PH_IDLE;
                do_end    = 1'b1;
              end
            endcase
          end
        end
        KIND_CONFD: begin
          nxt.slot = sid_q;
          bump     = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (do_begin) begin
      nxt.enum_flag = 1'b1;
    end
    if (do_end) begin
      nxt.enum_flag = 1'b0;
    end
  end

  // Counter update
  always_comb begin
    active_d = active_q;
    g_inc    = 2'(bump);
    if (do_begin && !cur.enum_flag) begin
      active_d = active_q + CNT_W'(1);
      g_inc    = g_inc + 2'd1;
    end
    if (do_end && cur.enum_flag) begin
      if (active_q != '0) begin
        active_d = active_q - CNT_W'(1);
      end
      g_inc = g_inc + 2'd1;
    end
    gen_d = gen_q + GEN_W'(g_inc);
  end

  assign wr_en = (state_q == S_EXEC) && port_ok;

  // Result items; a step with no action gives one "none" item
  always_comb begin
    res0_o            = '0;
    res1_o            = '0;
    res0_o.generation = gen_d;
    res0_o.active     = ACTCNT_W'(active_d);
    res1_o.generation = gen_d;
    res1_o.active     = ACTCNT_W'(active_d);
    push_o.p0         = (state_q == S_EXEC);
    push_o.p1         = (state_q == S_EXEC) && (n_res == 2'd2);
    if (n_res == 2'd2) begin
      res0_o.action = a0_act;
      res0_o.port   = port_q;
      res0_o.value  = a0_val;
      res0_o.slot   = a0_slot;
      res1_o.action = a1_act;
      res1_o.port   = port_q;
      res1_o.value  = a1_val;
      res1_o.speed  = a1_speed;
      res1_o.last   = 1'b1;
    end else if (n_res == 2'd1) begin
      res0_o.action = (a0_act == ACT_NONE) ? a1_act : a0_act;
      res0_o.port   = port_q;
      res0_o.value  = a0_val;
      res0_o.slot   = a0_slot;
      res0_o.speed  = a1_speed;
      res0_o.last   = 1'b1;
    end else begin
      res0_o.last = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= '0;
      gen_q    <= '0;
      valid_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        active_q <= active_d;
        gen_q    <= gen_d;
      end
      if (wr_en) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      poll_q     <= POLL_RST;
      limit_q    <= RETRY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_POLL:     poll_q     <= cfg_data_i;
        CFG_RETRY:    limit_q    <= cfg_data_i[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_kind_i;
      port_q <= in_port_i;
      stat_q <= in_status_i;
      sid_q  <= in_sid_i;
      idx_q  <= in_idx;
    end
  end

endmodule

// ===== sv/usb_port_hotplug_sequencer.sv =====
// ============================================================================
// usb_port_hotplug_sequencer
// Root-port hot-plug enumeration sequencer with per-port state in RAM.
// ============================================================================
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser kind, tdata port/status/slot
//  m_axis    out  m_axis_tvalid/tready    tdata result, tlast last
//  cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// Each item first reads its port entry from the state RAM, then modifies it,
// writes it back and queues its one or two results; one item at a time.
// A 4-entry result queue sits before m_axis; s_axis is ready only while
// the queue has room for two results, so a stalled consumer stalls input.
// After reset, port entries read as idle/zero through per-port valid bits;
// no clearing pass is needed and the block is ready at once.
module usb_port_hotplug_sequencer
  import hps_pkg::*;
#(
  parameter int NUM_PORTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [4:0] port, [36:5] port_status, [44:37] slot_id, [47:45] zero
  input  logic [47:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] action, [7:3] out_port, [39:8] value, [47:40] slot, [51:48] speed,
  // [56:52] active_count, [120:57] generation, [127:121] zero
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  push_t push;
  res_t  res0, res1, out_res;
  logic  room;

  hps_exec #(
    .NUM_PORTS (NUM_PORTS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_port_i   (s_axis_tdata[4:0]),
    .in_status_i (s_axis_tdata[36:5]),
    .in_sid_i    (s_axis_tdata[44:37]),
    .room_i      (room),
    .push_o      (push),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  hps_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  // Pack the result item
  assign m_axis_tdata = {7'b0, out_res.generation, out_res.active, out_res.speed,
                         out_res.slot, out_res.value, out_res.port, out_res.action};
  assign m_axis_tlast = out_res.last;

endmodule

// ===== sv/hps_checker.sv =====
// ============================================================================
// hps_checker
// Port-level checks for the hot-plug sequencer, bound to the top level.
// ============================================================================
module hps_checker
  import hps_pkg::*;
#(
  parameter int NUM_PORTS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("result changed under stall");

  // One item at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous item in flight");

  // Enumeration count stays within the port count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[56:52]) <= 32'(NUM_PORTS))
    else $error("active count above port count");

  // A "none" result is the only result of its item and names no port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == ACT_NONE |->
      m_axis_tlast && m_axis_tdata[7:3] == '0)
    else $error("none result not alone");

endmodule

bind usb_port_hotplug_sequencer hps_checker #(.NUM_PORTS(NUM_PORTS)) u_hps_checker (.*);

// ===== tb/tb_usb_port_hotplug_sequencer.sv =====
// ============================================================================
// tb_usb_port_hotplug_sequencer
// Self-checking bench for the root-port hot-plug sequencer. A scoreboard model
// of the per-port phase machines predicts the one or two result items of
// every input item. Stimulus starts with hand-picked corner cases, then
// random enumeration sessions mixed with noise. Six register settings are
// used, extremes included. Both stream sides idle at random, and the output
// side holds off for long stretches to back up the input.
// ============================================================================
module tb_usb_port_hotplug_sequencer import hps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPORT       = 16;
  localparam int MAX_CYCLES  = 400000;
  localparam int LAT_CYCLES  = 4;
  localparam int PHASE_ITEMS = 220;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

  // One input item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
  } item_t;

  // One result item
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PORT_W-1:0]   port;
    logic [STAT_W-1:0]   value;
    logic [SLOT_W-1:0]   slot;
    logic [SPEED_W-1:0]  speed;
    logic [ACTCNT_W-1:0] active;
    logic [GEN_W-1:0]    gen;
    logic                last;
  } result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [1:0]   cfg_idx_i     = CFG_DEBOUNCE;
  logic [15:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata  = '0;  // [4:0] port, [36:5] status, [44:37] slot
  logic [1:0]   s_axis_tuser  = '0;  // [1:0] kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [2:0] action, [7:3] port, [39:8] value, [47:40] slot, [51:48] speed,
  // [56:52] active_count, [120:57] generation
  logic [127:0] m_axis_tdata;
  logic         m_axis_tlast;

  usb_port_hotplug_sequencer #(.NUM_PORTS(NPORT)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Scoreboard copy of the port state and registers
  logic [PHASE_W-1:0]  port_ph   [1:NPORT];
  logic [RETRY_W-1:0]  poll_cnt  [1:NPORT];
  logic [SLOT_W-1:0]   slot_bind [1:NPORT];
  bit                  enum_on   [1:NPORT];
  logic [ACTCNT_W-1:0] busy_ports;
  logic [GEN_W-1:0]    activity;
  logic [CFG_W-1:0]    debounce_ms;
  logic [CFG_W-1:0]    poll_ms;
  logic [RETRY_W-1:0]  retry_lim;

  result_t action_q[$];   // predicted results, oldest first
  item_t   pending[$];    // items waiting for the driver
  int      n_queued   = 0;
  int      n_results  = 0;
  int      mismatches = 0;
  int      cycles     = 0;

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------
  function automatic result_t mk_res(input logic [ACTION_W-1:0] a,
                                     input logic [PORT_W-1:0] p,
                                     input logic [STAT_W-1:0] v,
                                     input logic [SLOT_W-1:0] s,
                                     input logic [SPEED_W-1:0] sp);
    result_t r;
    r        = '0;
    r.action = a;
    r.port   = p;
    r.value  = v;
    r.slot   = s;
    r.speed  = sp;
    return r;
  endfunction

  // Port leaves enumeration; the active count never goes below zero
  function automatic void stop_enum(input int p);
    if (enum_on[p]) begin
      enum_on[p] = 1'b0;
      if (busy_ports != 0) busy_ports = busy_ports - 1'b1;
      activity = activity + 1'b1;
    end
  endfunction

  task automatic predict_actions(input item_t it);
    result_t            step_out[$];
    logic [STAT_W-1:0]  wr;
    logic [RETRY_W-1:0] r;
    int                 p;
    p = it.port;
    if (it.port >= 1 && it.port <= NPORT && it.kind != KIND_BAD) begin
      case (it.kind)
        KIND_STATUS: begin
          if (it.status[ST_CONNECT]) begin
            // connect only starts a session on an idle port
            if (port_ph[p] == PH_IDLE) begin
              port_ph[p] = PH_STABLE;
              if (!enum_on[p]) begin
                enum_on[p] = 1'b1;
                busy_ports = busy_ports + 1'b1;
                activity   = activity + 1'b1;
              end
              poll_cnt[p] = '0;
              step_out.push_back(mk_res(ACT_TIMER, it.port, 32'(debounce_ms), 0, 0));
            end
          end else begin
            // disconnect: binding is kept, so it is reported every time
            port_ph[p] = PH_IDLE;
            stop_enum(p);
            if (slot_bind[p] != 0)
              step_out.push_back(mk_res(ACT_INVAL, it.port, 0, slot_bind[p], 0));
          end
        end
        KIND_TIMER: begin
          if (!it.status[ST_CONNECT] && port_ph[p] != PH_IDLE) begin
            port_ph[p] = PH_IDLE;
            stop_enum(p);
          end else begin
            case (port_ph[p])
              PH_IDLE: ;
              PH_STABLE: begin
                activity = activity + 1'b1;
                wr = '0;
                wr[ST_POWER] = it.status[ST_POWER];
                wr[WR_RESET] = 1'b1;
                step_out.push_back(mk_res(ACT_WRITE, it.port, wr, 0, 0));
                port_ph[p] = PH_RESET;
                step_out.push_back(mk_res(ACT_TIMER, it.port, 32'(poll_ms), 0, 0));
              end
              PH_RESET: begin
                activity = activity + 1'b1;
                if (it.status[ST_ENABLE]) begin
                  port_ph[p] = PH_CONFIG;
                  step_out.push_back(mk_res(ACT_RERUN, it.port, 0, 0, 0));
                end else begin
                  r = poll_cnt[p];
                  if (r != RETRY_MAX) poll_cnt[p] = r + 1'b1;
                  if (r < retry_lim) begin
                    step_out.push_back(mk_res(ACT_TIMER, it.port, 32'(poll_ms), 0, 0));
                  end else begin
                    port_ph[p] = PH_ERROR;
                    stop_enum(p);
                  end
                end
              end
              PH_CONFIG: begin
                activity = activity + 1'b1;
                if (slot_bind[p] != 0) begin
                  step_out.push_back(mk_res(ACT_DISABLE, it.port, 0, slot_bind[p], 0));
                  slot_bind[p] = '0;
                end
                step_out.push_back(mk_res(ACT_CONFIG, it.port, 0, 0,
                                          it.status[ST_SPD_LO +: SPEED_W]));
                port_ph[p] = PH_IDLE;
                stop_enum(p);
              end
              default: begin
                port_ph[p] = PH_IDLE;
                stop_enum(p);
              end
            endcase
          end
        end
        default: begin
          // device configured notice
          slot_bind[p] = it.slot;
          activity = activity + 1'b1;
        end
      endcase
    end
    if (step_out.size() == 0) step_out.push_back(mk_res(ACT_NONE, 0, 0, 0, 0));
    // counts reported are those after the whole step
    foreach (step_out[k]) begin
      step_out[k].active = busy_ports;
      step_out[k].gen    = activity;
      step_out[k].last   = (k == step_out.size() - 1);
      action_q.push_back(step_out[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: bursts of items with random gaps
  // --------------------------------------------------------------------------
  item_t cur_item  = '0;
  int    burst_left = 0;
  int    gap_left   = 0;

  always @(posedge clk_i) begin : drv
    item_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_actions(cur_item);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        nxt           = pending.pop_front();
        cur_item      <= nxt;
        s_axis_tdata  <= {3'b000, nxt.slot, nxt.status, nxt.port};
        s_axis_tuser  <= nxt.kind;
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: rotating stall pattern, plus long hold-offs
  // --------------------------------------------------------------------------
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_left  = 0;
  int          hold_left = 0;
  int          taken_cnt = 0;

  always @(posedge clk_i) begin : rcv
    bit rdy;
    bit took;
    took = m_axis_tvalid && m_axis_tready;
    if (took) taken_cnt = taken_cnt + 1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rdy = 1'b0;
    end else if (took && (taken_cnt == 300 || taken_cnt == 1200)) begin
      hold_left = HOLD_CYCLES;
      rdy = 1'b0;
    end else begin
      if (pat_left == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
        pat_left  = $urandom_range(50, 300);
      end
      pat_left  = pat_left - 1;
      rdy       = stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
    m_axis_tready <= rdy;
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("[%0t] result %0d: %s is %0h, predicted %0h",
               $time, n_results, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : mon
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action = m_axis_tdata[2:0];
      got.port   = m_axis_tdata[7:3];
      got.value  = m_axis_tdata[39:8];
      got.slot   = m_axis_tdata[47:40];
      got.speed  = m_axis_tdata[51:48];
      got.active = m_axis_tdata[56:52];
      got.gen    = m_axis_tdata[120:57];
      got.last   = m_axis_tlast;
      if (action_q.size() == 0) begin
        report_mismatch("unexpected result, action", got.action, 0);
      end else begin
        want = action_q.pop_front();
        if (got.action !== want.action) report_mismatch("action", got.action, want.action);
        if (got.port !== want.port)     report_mismatch("out_port", got.port, want.port);
        if (got.value !== want.value)   report_mismatch("value", got.value, want.value);
        if (got.slot !== want.slot)     report_mismatch("slot", got.slot, want.slot);
        if (got.speed !== want.speed)   report_mismatch("speed", got.speed, want.speed);
        if (got.active !== want.active) report_mismatch("active_count", got.active, want.active);
        if (got.gen !== want.gen)       report_mismatch("generation", got.gen, want.gen);
        if (got.last !== want.last)     report_mismatch("last", got.last, want.last);
      end
      n_results++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [KIND_W-1:0] k, input logic [PORT_W-1:0] p,
                           input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] s);
    item_t it;
    it.kind   = k;
    it.port   = p;
    it.status = st;
    it.slot   = s;
    pending.push_back(it);
    n_queued++;
  endtask

  function automatic logic [STAT_W-1:0] rand_stat(input bit conn, input bit en);
    logic [STAT_W-1:0] st;
    st = $urandom;
    st[ST_CONNECT] = conn;
    st[ST_ENABLE]  = en;
    return st;
  endfunction

  // A mostly well-formed enumeration session on one port, with random tails
  task automatic add_session(input logic [PORT_W-1:0] p);
    int polls;
    int tail;
    if ($urandom_range(0, 3) == 0)
      push_item(KIND_STATUS, p, rand_stat(1'b0, 1'($urandom)), SLOT_W'($urandom));
    if ($urandom_range(0, 2) == 0) push_item(KIND_CONFD, p, $urandom, SLOT_W'($urandom));
    push_item(KIND_STATUS, p, rand_stat(1'b1, 1'($urandom)), SLOT_W'($urandom));
    push_item(KIND_TIMER, p, rand_stat(1'b1, 1'($urandom)), SLOT_W'($urandom));
    polls = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
    repeat (polls) push_item(KIND_TIMER, p, rand_stat(1'b1, 1'b0), SLOT_W'($urandom));
    tail = $urandom_range(0, 9);
    if (tail < 7) begin
      push_item(KIND_TIMER, p, rand_stat(1'b1, 1'b1), SLOT_W'($urandom));
      if ($urandom_range(0, 1) == 0) push_item(KIND_CONFD, p, $urandom, SLOT_W'($urandom));
      push_item(KIND_TIMER, p, rand_stat(1'b1, 1'($urandom)), SLOT_W'($urandom));
    end else if (tail == 7) begin
      push_item(KIND_TIMER, p, rand_stat(1'b0, 1'($urandom)), SLOT_W'($urandom));
    end else if (tail == 8) begin
      push_item(KIND_STATUS, p, rand_stat(1'b0, 1'($urandom)), SLOT_W'($urandom));
    end else begin
      push_item(KIND_TIMER, p, rand_stat(1'($urandom), 1'($urandom)), SLOT_W'($urandom));
    end
  endtask

  // Wait until the block has delivered everything predicted
  task automatic wait_drain();
    do @(posedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || action_q.size() != 0);
    repeat (LAT_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only with the block drained
  task automatic set_cfg(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] poll,
                         input logic [RETRY_W-1:0] lim);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DEBOUNCE;
    cfg_data_i <= deb;
    debounce_ms = deb;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_POLL;
    cfg_data_i <= poll;
    poll_ms = poll;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RETRY;
    cfg_data_i <= {13'b0, lim};
    retry_lim = lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stim
    int n0;
    int kd;
    for (int i = 1; i <= NPORT; i++) begin
      port_ph[i]   = PH_IDLE;
      poll_cnt[i]  = '0;
      slot_bind[i] = '0;
      enum_on[i]   = 1'b0;
    end
    busy_ports  = '0;
    activity    = '0;
    debounce_ms = DEBOUNCE_RST;
    poll_ms     = POLL_RST;
    retry_lim   = RETRY_RST;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad ports and unknown kind
    push_item(KIND_STATUS, 5'd0, 32'h1, 8'h00);
    push_item(KIND_TIMER, 5'd17, '1, 8'hFF);
    push_item(KIND_CONFD, 5'd31, '1, 8'hFF);
    push_item(KIND_BAD, 5'd1, 32'h3, 8'h11);
    // timer on an idle port
    push_item(KIND_TIMER, 5'd1, '1, 8'h00);
    // full session on the top port with a bound slot
    push_item(KIND_CONFD, 5'd16, 32'h0, 8'hFF);
    push_item(KIND_STATUS, 5'd16, '1, 8'h00);
    push_item(KIND_STATUS, 5'd16, '1, 8'h00);
    push_item(KIND_TIMER, 5'd16, '1, 8'h00);
    push_item(KIND_TIMER, 5'd16, 32'hFFFF_FFFD, 8'h00);
    push_item(KIND_TIMER, 5'd16, '1, 8'h00);
    push_item(KIND_TIMER, 5'd16, '1, 8'h00);
    // connection lost during a timer step
    push_item(KIND_STATUS, 5'd1, 32'h1, 8'h00);
    push_item(KIND_TIMER, 5'd1, 32'h0, 8'h00);
    // disconnect with a bound slot, twice
    push_item(KIND_CONFD, 5'd1, 32'h0, 8'h5A);
    push_item(KIND_STATUS, 5'd1, 32'h1, 8'h00);
    push_item(KIND_STATUS, 5'd1, 32'h0, 8'h00);
    push_item(KIND_STATUS, 5'd1, 32'hFFFF_FFFE, 8'h00);
    // reset polls run out, then the error phase clears
    push_item(KIND_STATUS, 5'd2, 32'h1, 8'h00);
    push_item(KIND_TIMER, 5'd2, 32'h1, 8'h00);
    repeat (6) push_item(KIND_TIMER, 5'd2, 32'h1, 8'h00);
    push_item(KIND_TIMER, 5'd2, 32'h1, 8'h00);
    wait_drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_cfg(16'h0000, 16'h0000, 3'd0);
        1:       set_cfg(16'hFFFF, 16'hFFFF, 3'd6);
        default: set_cfg(CFG_W'($urandom), CFG_W'($urandom),
                         RETRY_W'($urandom_range(0, 6)));
      endcase
      n0 = n_queued;
      while (n_queued - n0 < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any kind, sometimes an out-of-range port
          kd = $urandom_range(0, 3);
          push_item(KIND_W'(kd),
                    PORT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(1, NPORT)),
                    $urandom, SLOT_W'($urandom));
        end else begin
          add_session(PORT_W'($urandom_range(1, NPORT)));
        end
      end
      wait_drain();
    end

    repeat (LAT_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && action_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
